/* rtl/core/llde_pkg.sv */
// Shared types, codes and the generator step of the lossy link emulator.
package llde_pkg;

  localparam logic [2:0] REQ_SEND       = 3'd0;
  localparam logic [2:0] REQ_POLL       = 3'd1;
  localparam logic [2:0] REQ_CONNECT    = 3'd2;
  localparam logic [2:0] REQ_LISTEN     = 3'd3;
  localparam logic [2:0] REQ_DISCONNECT = 3'd4;

  localparam logic [1:0] KIND_NONE         = 2'd0;
  localparam logic [1:0] KIND_CONNECTED    = 2'd1;
  localparam logic [1:0] KIND_MESSAGE      = 2'd2;
  localparam logic [1:0] KIND_DISCONNECTED = 2'd3;

  localparam logic [1:0] CFG_LATENCY = 2'd0;
  localparam logic [1:0] CFG_JITTER  = 2'd1;
  localparam logic [1:0] CFG_LOSS    = 2'd2;
  localparam logic [1:0] CFG_SEED    = 2'd3;

  localparam logic [1:0]  CHAN_UNRELIABLE = 2'd1;
  localparam logic [15:0] VIRTUAL_PEER    = 16'd1;
  localparam logic [31:0] SEED_DEFAULT    = 32'h9E37_79B9;
  localparam logic [15:0] DROP_MAX        = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOSS, ST_JIT, ST_DIV, ST_CALC, ST_INS,
    ST_SRD, ST_SCHK, ST_FRD, ST_FCHK, ST_END
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  chan;
    logic [31:0] tag;
    logic [15:0] size;
  } event_t;

  typedef struct packed {
    logic [7:0]  left;
    logic [1:0]  chan;
    logic [31:0] tag;
    logic [15:0] size;
  } slot_t;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] x;
    x = v ^ (v << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

/* rtl/core/lossy_link_delay_emulator_top.sv */
// Lossy loopback link emulator: delay table and event FIFO in block memories.
// Send, connect, listen, disconnect: done in idle; an unreliable send with jitter
// takes a loss draw (if set), a jitter draw, the bit-serial modulo (32 steps), the
// delay sum and the insert. Poll reads and checks each delay entry, then each FIFO
// entry, then ends; results are strobed one cycle each and cannot be stalled.
// rst_n is synchronous, active low; memories need no clearing pass.
module lossy_link_delay_emulator_top #(
  parameter int DELAY_SLOTS = 16,
  parameter int FIFO_SLOTS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [15:0] in_target_peer,
  input  logic [1:0]  in_channel_code,
  input  logic [31:0] in_message_tag,
  input  logic [15:0] in_message_size,
  output logic        out_valid,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_event_peer,
  output logic [1:0]  out_event_channel,
  output logic [31:0] out_event_tag,
  output logic [15:0] out_event_size,
  output logic        out_last_event,
  output logic        out_server_mode,
  output logic        out_peer_present,
  output logic [15:0] out_overflow_drops,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SIW = $clog2(DELAY_SLOTS);
  localparam int SCW = $clog2(DELAY_SLOTS + 1);
  localparam int FIW = $clog2(FIFO_SLOTS);
  localparam int FCW = $clog2(FIFO_SLOTS + 1);

  llde_pkg::state_t state_r, state_nxt;

  logic [6:0]  lat_r, jit_r;
  logic [24:0] thr_r;
  logic [31:0] rng_r, last_seed_r;
  logic        srv_r, link_r;
  logic [SCW-1:0] slot_cnt_r;
  logic [SIW-1:0] i_r, w_r;
  logic [FIW-1:0] head_r;
  logic [FCW-1:0] fcnt_r;
  logic [15:0] drop_r;
  logic [31:0] tag_r, div_r;
  logic [15:0] size_r;
  logic [1:0]  chan_r;
  logic [7:0]  rem_r, dly_r;
  logic [4:0]  bit_r;
  llde_pkg::event_t pend_r, ev_out_r;
  logic        pend_vld_r, out_valid_r, out_last_r;

  // memories
  llde_pkg::slot_t  slot_mem [DELAY_SLOTS];
  llde_pkg::event_t fifo_mem [FIFO_SLOTS];
  llde_pkg::slot_t  slot_rd;
  llde_pkg::event_t fifo_rd;
  logic             slot_we, fifo_we;
  logic [SIW-1:0]   slot_wa, slot_ra;
  logic [FIW-1:0]   fifo_wa;
  llde_pkg::slot_t  slot_wd;
  llde_pkg::event_t fifo_wd;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_wa] <= slot_wd;
    slot_rd <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
    fifo_rd <= fifo_mem[head_r];
  end

  logic        accept, active, peer_ok, s_last, f_last, emit_vld;
  logic [31:0] draw;
  logic [7:0]  span;
  logic [8:0]  trial;
  logic [9:0]  dsum;
  logic [FCW:0] fpos;
  logic [FIW:0] head_inc;
  llde_pkg::event_t emit_ev;

  assign accept   = start && !busy;
  assign active   = (lat_r != 7'd0) || (jit_r != 7'd0) || (thr_r != 25'd0);
  assign peer_ok  = in_target_peer == llde_pkg::VIRTUAL_PEER;
  assign draw     = llde_pkg::xorshift(rng_r);
  assign span     = {jit_r, 1'b1};
  assign trial    = {rem_r, div_r[31]};
  assign dsum     = {3'd0, lat_r} + {2'd0, rem_r};
  assign s_last   = {1'b0, i_r} == SCW'(slot_cnt_r - 1'b1);
  assign f_last   = fcnt_r == FCW'(1);
  assign fpos     = (FCW+1)'(head_r) + (FCW+1)'(fcnt_r);
  assign head_inc = (FIW+1)'(head_r) + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llde_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            llde_pkg::REQ_SEND:
              if (link_r && peer_ok && active
                  && in_channel_code == llde_pkg::CHAN_UNRELIABLE) begin
                if (thr_r != 25'd0)      state_nxt = llde_pkg::ST_LOSS;
                else if (jit_r != 7'd0)  state_nxt = llde_pkg::ST_JIT;
                else                     state_nxt = llde_pkg::ST_INS;
              end
            llde_pkg::REQ_POLL:
              if (slot_cnt_r != '0)     state_nxt = llde_pkg::ST_SRD;
              else if (fcnt_r != '0)    state_nxt = llde_pkg::ST_FRD;
              else                      state_nxt = llde_pkg::ST_END;
            default: state_nxt = llde_pkg::ST_IDLE;
          endcase
        end
      end
      llde_pkg::ST_LOSS: begin
        if (draw[31:8] < thr_r)   state_nxt = llde_pkg::ST_IDLE;
        else if (jit_r != 7'd0)   state_nxt = llde_pkg::ST_JIT;
        else                      state_nxt = llde_pkg::ST_INS;
      end
      llde_pkg::ST_JIT:  state_nxt = llde_pkg::ST_DIV;
      llde_pkg::ST_DIV:  if (bit_r == 5'd31) state_nxt = llde_pkg::ST_CALC;
      llde_pkg::ST_CALC: state_nxt = llde_pkg::ST_INS;
      llde_pkg::ST_INS:  state_nxt = llde_pkg::ST_IDLE;
      llde_pkg::ST_SRD:  state_nxt = llde_pkg::ST_SCHK;
      llde_pkg::ST_SCHK: begin
        if (!s_last)            state_nxt = llde_pkg::ST_SRD;
        else if (fcnt_r != '0)  state_nxt = llde_pkg::ST_FRD;
        else                    state_nxt = llde_pkg::ST_END;
      end
      llde_pkg::ST_FRD:  state_nxt = llde_pkg::ST_FCHK;
      llde_pkg::ST_FCHK: state_nxt = f_last ? llde_pkg::ST_END : llde_pkg::ST_FRD;
      llde_pkg::ST_END:  state_nxt = llde_pkg::ST_IDLE;
      default:           state_nxt = llde_pkg::ST_IDLE;
    endcase
  end

  // memory control and emitted events
  always_comb begin
    fifo_we  = 1'b0;
    fifo_wd  = '0;
    slot_we  = 1'b0;
    slot_wa  = SIW'(slot_cnt_r);
    slot_wd  = '{left: dly_r, chan: chan_r, tag: tag_r, size: size_r};
    slot_ra  = i_r;
    emit_vld = 1'b0;
    emit_ev  = '0;
    fifo_wa  = (fpos >= (FCW+1)'(FIFO_SLOTS)) ? FIW'(fpos - (FCW+1)'(FIFO_SLOTS))
                                              : FIW'(fpos);
    case (state_r)
      llde_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            llde_pkg::REQ_SEND: begin
              fifo_wd = '{kind: llde_pkg::KIND_MESSAGE, chan: in_channel_code,
                          tag: in_message_tag, size: in_message_size};
              fifo_we = link_r && peer_ok
                        && !(active && in_channel_code == llde_pkg::CHAN_UNRELIABLE);
            end
            llde_pkg::REQ_CONNECT, llde_pkg::REQ_LISTEN: begin
              fifo_wd.kind = llde_pkg::KIND_CONNECTED;
              fifo_we      = 1'b1;
            end
            llde_pkg::REQ_DISCONNECT: begin
              fifo_wd.kind = llde_pkg::KIND_DISCONNECTED;
              fifo_we      = link_r && peer_ok;
            end
            default: fifo_we = 1'b0;
          endcase
          if (fcnt_r >= FCW'(FIFO_SLOTS)) fifo_we = 1'b0;
        end
      end
      llde_pkg::ST_INS: slot_we = slot_cnt_r < SCW'(DELAY_SLOTS);
      llde_pkg::ST_SCHK: begin
        if (slot_rd.left == 8'd0) begin
          emit_vld = 1'b1;
          emit_ev  = '{kind: llde_pkg::KIND_MESSAGE, chan: slot_rd.chan,
                       tag: slot_rd.tag, size: slot_rd.size};
        end else begin
          slot_we      = 1'b1;
          slot_wa      = w_r;
          slot_wd      = slot_rd;
          slot_wd.left = slot_rd.left - 8'd1;
        end
      end
      llde_pkg::ST_FCHK: begin
        emit_vld = 1'b1;
        emit_ev  = fifo_rd;
      end
      default: emit_vld = 1'b0;
    endcase
  end

  logic full_drop;
  assign full_drop = (state_r == llde_pkg::ST_IDLE && accept && !fifo_we
                      && fcnt_r >= FCW'(FIFO_SLOTS)
                      && ((in_req_type == llde_pkg::REQ_SEND && link_r && peer_ok
                           && !(active && in_channel_code == llde_pkg::CHAN_UNRELIABLE))
                          || in_req_type == llde_pkg::REQ_CONNECT
                          || in_req_type == llde_pkg::REQ_LISTEN
                          || (in_req_type == llde_pkg::REQ_DISCONNECT
                              && link_r && peer_ok)))
                     || (state_r == llde_pkg::ST_INS && !slot_we);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= llde_pkg::ST_IDLE;
      lat_r       <= '0;
      jit_r       <= '0;
      thr_r       <= '0;
      rng_r       <= llde_pkg::SEED_DEFAULT;
      last_seed_r <= '0;
      srv_r       <= 1'b0;
      link_r      <= 1'b0;
      slot_cnt_r  <= '0;
      head_r      <= '0;
      fcnt_r      <= '0;
      drop_r      <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == llde_pkg::ST_END) || (emit_vld && pend_vld_r);
      if (cfg_valid) begin
        case (cfg_index)
          llde_pkg::CFG_LATENCY: lat_r <= cfg_data[6:0];
          llde_pkg::CFG_JITTER:  jit_r <= cfg_data[6:0];
          llde_pkg::CFG_LOSS:    thr_r <= cfg_data[24:0];
          llde_pkg::CFG_SEED:
            if (cfg_data != last_seed_r) begin
              rng_r       <= (cfg_data != 32'd0) ? cfg_data : llde_pkg::SEED_DEFAULT;
              last_seed_r <= cfg_data;
            end
          default: lat_r <= lat_r;
        endcase
      end
      if (full_drop && drop_r != llde_pkg::DROP_MAX) drop_r <= drop_r + 16'd1;
      if (fifo_we) fcnt_r <= fcnt_r + 1'b1;
      if (slot_we && state_r == llde_pkg::ST_INS) slot_cnt_r <= slot_cnt_r + 1'b1;
      case (state_r)
        llde_pkg::ST_IDLE:
          if (accept) begin
            if (in_req_type == llde_pkg::REQ_CONNECT || in_req_type == llde_pkg::REQ_LISTEN)
            begin
              srv_r  <= in_req_type == llde_pkg::REQ_LISTEN;
              link_r <= 1'b1;
            end
            if (in_req_type == llde_pkg::REQ_DISCONNECT && link_r && peer_ok)
              link_r <= 1'b0;
          end
        llde_pkg::ST_LOSS: rng_r <= draw;
        llde_pkg::ST_JIT:  rng_r <= draw;
        llde_pkg::ST_SCHK:
          if (s_last) slot_cnt_r <= SCW'(w_r) + SCW'(slot_rd.left != 8'd0);
        llde_pkg::ST_FCHK: begin
          head_r <= (head_inc >= (FIW+1)'(FIFO_SLOTS)) ? '0 : FIW'(head_inc);
          fcnt_r <= fcnt_r - 1'b1;
        end
        llde_pkg::ST_END: begin
          out_last_r  <= 1'b1;
          ev_out_r    <= pend_vld_r ? pend_r : '0;
          pend_vld_r  <= 1'b0;
        end
        default: pend_vld_r <= pend_vld_r;
      endcase
      // one result held back so the final one can carry the last flag
      if (emit_vld) begin
        pend_r     <= emit_ev;
        pend_vld_r <= 1'b1;
        if (pend_vld_r) begin
          out_last_r  <= 1'b0;
          ev_out_r    <= pend_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      llde_pkg::ST_IDLE: begin
        tag_r  <= in_message_tag;
        size_r <= in_message_size;
        chan_r <= in_channel_code;
        dly_r  <= {1'b0, lat_r};
        i_r    <= '0;
        w_r    <= '0;
      end
      llde_pkg::ST_LOSS: dly_r <= {1'b0, lat_r};
      llde_pkg::ST_JIT: begin
        div_r <= draw;
        rem_r <= '0;
        bit_r <= '0;
      end
      llde_pkg::ST_DIV: begin
        div_r <= div_r << 1;
        rem_r <= (trial >= {1'b0, span}) ? 8'(trial - {1'b0, span}) : trial[7:0];
        bit_r <= bit_r + 5'd1;
      end
      llde_pkg::ST_CALC:
        dly_r <= (dsum >= {3'd0, jit_r}) ? 8'(dsum - {3'd0, jit_r}) : 8'd0;
      llde_pkg::ST_SCHK: begin
        i_r <= i_r + 1'b1;
        if (slot_rd.left != 8'd0) w_r <= w_r + 1'b1;
      end
      default: dly_r <= dly_r;
    endcase
  end

  assign busy               = state_r != llde_pkg::ST_IDLE;
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_event_kind     = ev_out_r.kind;
  assign out_event_peer     = (ev_out_r.kind != llde_pkg::KIND_NONE)
                              ? llde_pkg::VIRTUAL_PEER : 16'd0;
  assign out_event_channel  = ev_out_r.chan;
  assign out_event_tag      = ev_out_r.tag;
  assign out_event_size     = ev_out_r.size;
  assign out_last_event     = out_last_r;
  assign out_server_mode    = srv_r;
  assign out_peer_present   = link_r;
  assign out_overflow_drops = drop_r;

`ifndef SYNTHESIS
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_cnt_r <= SCW'(DELAY_SLOTS)) else $error("delay table count overrun");
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCW'(FIFO_SLOTS)) else $error("event queue count overrun");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == llde_pkg::KIND_NONE |-> out_last_event)
    else $error("empty poll result without last flag");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_event |-> !busy) else $error("poll ended while still busy");
`endif

endmodule
